/* rtl/sha1md_pkg.sv */
// shared types, constants and helper functions of the sha1 digest engine
// no dependencies; used by the controller, the datapath and the top level
package sha1md_pkg;

   localparam int unsigned ChainWords = 5;
   localparam int unsigned BlockWords = 16;
   localparam int unsigned Rounds     = 80;

   localparam logic [6:0] LastRound   = 7'd79;
   localparam logic [5:0] LastFill    = 6'd63;
   localparam logic [5:0] LenFill     = 6'd56;
   localparam logic [2:0] LastLenByte = 3'd7;
   localparam logic [2:0] LastWordIdx = 3'd4;
   localparam logic [7:0] PadMark     = 8'h80;

   localparam logic [31:0] InitChain [ChainWords] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_COMP,
      S_ADD,
      S_PAD80,
      S_PADZ,
      S_LEN,
      S_EMIT
   } ctrl_state_type;

   // source of a byte pushed into the block
   typedef enum logic [1:0] {
      SEL_MSG,
      SEL_MARK,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic         push;
      byte_sel_type sel;
      logic         load;
      logic         round;
      logic         chain_add;
      logic         emit;
   } dp_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic [5:0] fill;
      logic       round_last;
      logic       out_busy;
   } dp_status_type;

   // round constant by round number
   function automatic logic [31:0] round_k(input logic [6:0] rnd);
      logic [31:0] k;
      if (rnd < 7'd20) begin
         k = 32'h5A827999;
      end else if (rnd < 7'd40) begin
         k = 32'h6ED9EBA1;
      end else if (rnd < 7'd60) begin
         k = 32'h8F1BBCDC;
      end else begin
         k = 32'hCA62C1D6;
      end
      return k;
   endfunction

   // round function by round number
   function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      if (rnd < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (rnd < 7'd40) begin
         f = b ^ c ^ d;
      end else if (rnd < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

endpackage

/* rtl/sha1_message_digest_top.sv */
// SHA-1 message digest engine, top level: byte words in on the req_ channel,
// five 32-bit digest words out on the rsp_ channel, most significant word
// first. The word that completes a 64-byte block stalls the input while the
// block is hashed (80 rounds on the one shared round unit, one round per
// cycle, plus the chaining add). The end-of-message word starts padding,
// which pushes the 0x80 mark, up to 63 zero bytes and 8 length bytes, one
// per cycle, through the same block register, with one or two compressions,
// so the input stays stalled from a message end until the digest is loaded
// into its output buffer. The digest sits in its own output buffer, so bytes
// of the next message are taken while it drains; a second message end waits
// only if the previous digest has not all been taken.
// depends on sha1md_pkg, sha1md_ctrl and sha1md_datapath
module sha1_message_digest_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   sha1md_pkg::dp_cmd_type    cmd;
   sha1md_pkg::dp_status_type status;

   // sequencing
   sha1md_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_has_byte       (req_has_byte),
      .req_end_of_message (req_end_of_message),
      .status             (status),
      .cmd                (cmd)
   );

   // block, rounds, chaining and output buffer
   sha1md_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_msg_byte    (req_msg_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

endmodule

/* rtl/sha1md_datapath.sv */
// datapath of the sha1 digest engine: block shift register, round registers,
// chaining words, bit count and digest output buffer; uses sha1md_pkg
module sha1md_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  sha1md_pkg::dp_cmd_type   cmd,
   output sha1md_pkg::dp_status_type status,
   input  logic [7:0]               req_msg_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [31:0]              rsp_digest_word,
   output logic [2:0]               rsp_word_index,
   output logic                     rsp_last_word
);

   logic [31:0] blk_ff   [sha1md_pkg::BlockWords];
   logic [31:0] blk_in   [sha1md_pkg::BlockWords];
   logic [31:0] regs_ff  [sha1md_pkg::ChainWords];
   logic [31:0] regs_in  [sha1md_pkg::ChainWords];
   logic [31:0] chain_ff [sha1md_pkg::ChainWords];
   logic [31:0] chain_in [sha1md_pkg::ChainWords];
   logic [31:0] out_ff   [sha1md_pkg::ChainWords];
   logic [31:0] out_in   [sha1md_pkg::ChainWords];
   logic [5:0]  fill_ff, fill_in;
   logic [6:0]  round_ff, round_in;
   logic [63:0] count_ff, count_in;
   logic        out_valid_ff, out_valid_in;
   logic [2:0]  idx_ff, idx_in;
   logic [7:0]  push_byte;
   logic [31:0] sched_word;
   logic [31:0] temp;
   logic        pop;

   // byte source select
   always_comb begin
      unique case (cmd.sel)
         sha1md_pkg::SEL_MSG:  push_byte = req_msg_byte;
         sha1md_pkg::SEL_MARK: push_byte = sha1md_pkg::PadMark;
         sha1md_pkg::SEL_ZERO: push_byte = 8'h00;
         sha1md_pkg::SEL_LEN:  push_byte = count_ff[63:56];
         default:              push_byte = 8'h00;
      endcase
   end

   // message schedule word and round sum
   assign sched_word = blk_ff[13] ^ blk_ff[8] ^ blk_ff[2] ^ blk_ff[0];
   assign temp = {regs_ff[0][26:0], regs_ff[0][31:27]}
               + sha1md_pkg::round_f(round_ff, regs_ff[1], regs_ff[2], regs_ff[3])
               + regs_ff[4] + sha1md_pkg::round_k(round_ff) + blk_ff[0];

   assign pop = out_valid_ff && !rsp_stall;

   // block register: byte shift while gathering, word shift while hashing
   always_comb begin
      for (int i = 0; i < sha1md_pkg::BlockWords; i++) begin
         blk_in[i] = blk_ff[i];
      end
      fill_in = fill_ff;
      if (cmd.push) begin
         for (int i = 0; i < sha1md_pkg::BlockWords - 1; i++) begin
            blk_in[i] = {blk_ff[i][23:0], blk_ff[i + 1][31:24]};
         end
         blk_in[sha1md_pkg::BlockWords - 1] =
            {blk_ff[sha1md_pkg::BlockWords - 1][23:0], push_byte};
         fill_in = fill_ff + 6'd1;
      end else if (cmd.round) begin
         for (int i = 0; i < sha1md_pkg::BlockWords - 1; i++) begin
            blk_in[i] = blk_ff[i + 1];
         end
         blk_in[sha1md_pkg::BlockWords - 1] = {sched_word[30:0], sched_word[31]};
      end
   end

   // working registers a..e and round counter
   always_comb begin
      for (int i = 0; i < sha1md_pkg::ChainWords; i++) begin
         regs_in[i] = regs_ff[i];
      end
      round_in = round_ff;
      if (cmd.load) begin
         for (int i = 0; i < sha1md_pkg::ChainWords; i++) begin
            regs_in[i] = chain_ff[i];
         end
         round_in = 7'd0;
      end else if (cmd.round) begin
         regs_in[0] = temp;
         regs_in[1] = regs_ff[0];
         regs_in[2] = {regs_ff[1][1:0], regs_ff[1][31:2]};
         regs_in[3] = regs_ff[2];
         regs_in[4] = regs_ff[3];
         round_in   = round_ff + 7'd1;
      end
   end

   // chaining words and bit count
   always_comb begin
      for (int i = 0; i < sha1md_pkg::ChainWords; i++) begin
         chain_in[i] = chain_ff[i];
      end
      count_in = count_ff;
      if (cmd.chain_add) begin
         for (int i = 0; i < sha1md_pkg::ChainWords; i++) begin
            chain_in[i] = chain_ff[i] + regs_ff[i];
         end
      end else if (cmd.emit) begin
         for (int i = 0; i < sha1md_pkg::ChainWords; i++) begin
            chain_in[i] = sha1md_pkg::InitChain[i];
         end
      end
      if (cmd.emit) begin
         count_in = 64'd0;
      end else if (cmd.push && cmd.sel == sha1md_pkg::SEL_MSG) begin
         count_in = count_ff + 64'd8;
      end else if (cmd.push && cmd.sel == sha1md_pkg::SEL_LEN) begin
         count_in = {count_ff[55:0], count_ff[63:56]};
      end
   end

   // digest output buffer, drained one word per handshake
   always_comb begin
      for (int i = 0; i < sha1md_pkg::ChainWords; i++) begin
         out_in[i] = out_ff[i];
      end
      out_valid_in = out_valid_ff;
      idx_in       = idx_ff;
      if (cmd.emit) begin
         for (int i = 0; i < sha1md_pkg::ChainWords; i++) begin
            out_in[i] = chain_ff[i];
         end
         out_valid_in = 1'b1;
         idx_in       = 3'd0;
      end else if (pop) begin
         for (int i = 0; i < sha1md_pkg::ChainWords - 1; i++) begin
            out_in[i] = out_ff[i + 1];
         end
         idx_in = idx_ff + 3'd1;
         if (idx_ff == sha1md_pkg::LastWordIdx) begin
            out_valid_in = 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < sha1md_pkg::BlockWords; i++) begin
         blk_ff[i] <= blk_in[i];
      end
      for (int i = 0; i < sha1md_pkg::ChainWords; i++) begin
         regs_ff[i] <= regs_in[i];
         out_ff[i]  <= out_in[i];
      end
   end

   // control and chaining state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= 6'd0;
         round_ff     <= 7'd0;
         count_ff     <= 64'd0;
         out_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
         for (int i = 0; i < sha1md_pkg::ChainWords; i++) begin
            chain_ff[i] <= sha1md_pkg::InitChain[i];
         end
      end else begin
         fill_ff      <= fill_in;
         round_ff     <= round_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
         for (int i = 0; i < sha1md_pkg::ChainWords; i++) begin
            chain_ff[i] <= chain_in[i];
         end
      end
   end

   assign status.fill       = fill_ff;
   assign status.round_last = (round_ff == sha1md_pkg::LastRound);
   assign status.out_busy   = out_valid_ff;

   assign rsp_valid       = out_valid_ff;
   assign rsp_digest_word = out_ff[0];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == sha1md_pkg::LastWordIdx);

   // round counter never runs past the count that ends the rounds
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      round_ff <= 7'(sha1md_pkg::Rounds))
      else $error("round counter out of range");

   // a new digest is never loaded over one still draining
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !out_valid_ff)
      else $error("digest loaded while buffer busy");

   // the fifth word taken empties the buffer
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_stall && rsp_last_word && !cmd.emit) |=> !out_valid_ff)
      else $error("buffer still valid after last word");

endmodule

/* rtl/sha1md_ctrl.sv */
// controller of the sha1 digest engine: accepts words, sequences padding,
// length bytes and compression rounds; uses sha1md_pkg
module sha1md_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_has_byte,
   input  logic                      req_end_of_message,
   input  sha1md_pkg::dp_status_type status,
   output sha1md_pkg::dp_cmd_type    cmd
);

   sha1md_pkg::ctrl_state_type state_ff, state_in;
   logic       fin_ff, fin_in;
   logic       mark_ff, mark_in;
   logic       len_done_ff, len_done_in;
   logic [2:0] len_cnt_ff, len_cnt_in;
   logic       block_full;

   assign block_full = (status.fill == sha1md_pkg::LastFill);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sha1md_pkg::S_IDLE;
         fin_ff      <= 1'b0;
         mark_ff     <= 1'b0;
         len_done_ff <= 1'b0;
         len_cnt_ff  <= 3'd0;
      end else begin
         state_ff    <= state_in;
         fin_ff      <= fin_in;
         mark_ff     <= mark_in;
         len_done_ff <= len_done_in;
         len_cnt_ff  <= len_cnt_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in    = state_ff;
      fin_in      = fin_ff;
      mark_in     = mark_ff;
      len_done_in = len_done_ff;
      len_cnt_in  = len_cnt_ff;
      cmd         = '0;
      cmd.sel     = sha1md_pkg::SEL_MSG;
      req_stall   = 1'b1;
      unique case (state_ff)
         sha1md_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               fin_in = req_end_of_message;
               if (req_has_byte) begin
                  cmd.push = 1'b1;
                  cmd.sel  = sha1md_pkg::SEL_MSG;
               end
               if (req_has_byte && block_full) begin
                  cmd.load = 1'b1;
                  state_in = sha1md_pkg::S_COMP;
               end else if (req_end_of_message) begin
                  state_in = sha1md_pkg::S_PAD80;
               end
            end
         end
         sha1md_pkg::S_COMP: begin
            cmd.round = 1'b1;
            if (status.round_last) begin
               state_in = sha1md_pkg::S_ADD;
            end
         end
         sha1md_pkg::S_ADD: begin
            cmd.chain_add = 1'b1;
            priority if (!fin_ff) begin
               state_in = sha1md_pkg::S_IDLE;
            end else if (len_done_ff) begin
               state_in = sha1md_pkg::S_EMIT;
            end else if (mark_ff) begin
               state_in = sha1md_pkg::S_PADZ;
            end else begin
               state_in = sha1md_pkg::S_PAD80;
            end
         end
         sha1md_pkg::S_PAD80: begin
            cmd.push = 1'b1;
            cmd.sel  = sha1md_pkg::SEL_MARK;
            mark_in  = 1'b1;
            if (block_full) begin
               cmd.load = 1'b1;
               state_in = sha1md_pkg::S_COMP;
            end else begin
               state_in = sha1md_pkg::S_PADZ;
            end
         end
         sha1md_pkg::S_PADZ: begin
            if (status.fill == sha1md_pkg::LenFill) begin
               len_cnt_in = 3'd0;
               state_in   = sha1md_pkg::S_LEN;
            end else begin
               cmd.push = 1'b1;
               cmd.sel  = sha1md_pkg::SEL_ZERO;
               if (block_full) begin
                  cmd.load = 1'b1;
                  state_in = sha1md_pkg::S_COMP;
               end
            end
         end
         sha1md_pkg::S_LEN: begin
            cmd.push   = 1'b1;
            cmd.sel    = sha1md_pkg::SEL_LEN;
            len_cnt_in = len_cnt_ff + 3'd1;
            if (len_cnt_ff == sha1md_pkg::LastLenByte) begin
               len_done_in = 1'b1;
               cmd.load    = 1'b1;
               state_in    = sha1md_pkg::S_COMP;
            end
         end
         sha1md_pkg::S_EMIT: begin
            if (!status.out_busy) begin
               cmd.emit    = 1'b1;
               fin_in      = 1'b0;
               mark_in     = 1'b0;
               len_done_in = 1'b0;
               state_in    = sha1md_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sha1md_pkg::S_IDLE;
         end
      endcase
   end

   // last round always hands over to the chaining add
   a_comp_to_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha1md_pkg::S_COMP && status.round_last) |=>
      state_ff == sha1md_pkg::S_ADD)
      else $error("compression did not end after last round");

   // compression only starts on a full block
   a_load_full: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (cmd.push && block_full))
      else $error("compression started on a partial block");

   // length bytes are sent only once the block is at the length slot
   a_len_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha1md_pkg::S_LEN && len_cnt_ff == 3'd0) |->
      status.fill == sha1md_pkg::LenFill)
      else $error("length field misaligned");

endmodule
